// ===== hw/rtl/cone_mesh_vertex_generator_macros.svh =====
// Assertion macros shared by the cone mesh vertex generator RTL
`ifndef CONE_MESH_VERTEX_GENERATOR_MACROS_SVH
`define CONE_MESH_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CMVG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cmvg_pkg.sv =====
// Package for the cone mesh vertex generator: constants, types and helpers
`default_nettype none

package cmvg_pkg;

	localparam int FRAC_BITS = 15;
	localparam int Q         = 30;
	localparam int OUT_W     = 16;
	localparam int RC_W      = 9;
	localparam int SC_W      = 11;
	localparam int SIDX_W    = 10;
	localparam int RIDX_W    = 8;

	localparam int MAX_RINGS    = 256;
	localparam int MAX_SEGMENTS = 1024;
	localparam int MIN_SEGMENTS = 3;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_RING_COUNT    = 1'b0;
	localparam logic REG_SEGMENT_COUNT = 1'b1;

	// divider: two angle lanes over S, two ring lanes over R
	localparam int DIV_LANES     = 4;
	localparam int LANE_A        = 0;
	localparam int LANE_B        = 1;
	localparam int LANE_R1       = 2;
	localparam int LANE_R2       = 3;
	localparam int DIV_STEPS     = 32;
	localparam int DIV_PER_STAGE = 4;
	localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
	localparam int REM_W         = 12;

	localparam int CORDIC_STEPS     = 30;
	localparam int CORDIC_PER_STAGE = 3;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int TRIG_LANES       = 2;
	localparam int CW               = 34;
	localparam int ZW               = 33;

	localparam int RAD_W  = 30;
	localparam int YW     = 31;
	localparam int PROD_W = 67;
	localparam int PP     = 2 * Q - FRAC_BITS;
	localparam int PS     = Q - FRAC_BITS;
	localparam int HALF_Q = 2 ** (Q - 1);

	localparam int CORDIC_GAIN_C  = 652032874;
	localparam int INV_SQRT_5_4_C = 960383883;

	localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(CORDIC_GAIN_C);
	localparam logic signed [31:0]   NRM_K        = 32'(INV_SQRT_5_4_C);
	localparam logic [RAD_W-1:0]     HALF_RAD     = RAD_W'(HALF_Q);
	localparam logic signed [YW-1:0] HALF_Y       = YW'(HALF_Q);

	localparam logic signed [OUT_W-1:0] POS_Y_BASE  =
		OUT_W'((-HALF_Q + 2 ** (PS - 1)) >>> PS);
	localparam logic signed [OUT_W-1:0] NORM_Y_BASE =
		OUT_W'((-(2 ** Q) + 2 ** (PS - 1)) >>> PS);
	localparam logic signed [OUT_W-1:0] NORM_Y_SIDE =
		OUT_W'((INV_SQRT_5_4_C / 2 + 2 ** (PS - 1)) >>> PS);

	localparam logic signed [PROD_W-1:0] OUT_MAX_P = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] OUT_MIN_P = PROD_W'(-32768);

	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	localparam int VTX_W = 4;
	localparam logic [VTX_W-1:0] VTX_LAST = 4'd11;

	typedef struct packed {
		logic [RAD_W-1:0]     r1;
		logic [RAD_W-1:0]     r2;
		logic [RAD_W-1:0]     sr1;
		logic [RAD_W-1:0]     sr2;
		logic signed [YW-1:0] y1;
		logic signed [YW-1:0] y2;
		logic                 tip;
	} ring_t;

	typedef struct packed {
		logic [1:0]           quad;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cordic_t;

	typedef struct packed {
		logic base;
		logic use_b;
		logic top;
	} vsel_t;

	// base: TL BL BR BR TR TL; side: TR BR BL BL TL TR
	function automatic vsel_t vtx_sel(input logic [VTX_W-1:0] k);
		vsel_t v;
		unique case (k)
			4'd0:    v = '{base: 1'b1, use_b: 1'b0, top: 1'b1};
			4'd1:    v = '{base: 1'b1, use_b: 1'b0, top: 1'b0};
			4'd2:    v = '{base: 1'b1, use_b: 1'b1, top: 1'b0};
			4'd3:    v = '{base: 1'b1, use_b: 1'b1, top: 1'b0};
			4'd4:    v = '{base: 1'b1, use_b: 1'b1, top: 1'b1};
			4'd5:    v = '{base: 1'b1, use_b: 1'b0, top: 1'b1};
			4'd6:    v = '{base: 1'b0, use_b: 1'b1, top: 1'b1};
			4'd7:    v = '{base: 1'b0, use_b: 1'b1, top: 1'b0};
			4'd8:    v = '{base: 1'b0, use_b: 1'b0, top: 1'b0};
			4'd9:    v = '{base: 1'b0, use_b: 1'b0, top: 1'b0};
			4'd10:   v = '{base: 1'b0, use_b: 1'b0, top: 1'b1};
			default: v = '{base: 1'b0, use_b: 1'b1, top: 1'b1};
		endcase
		return v;
	endfunction

	// round half up, arithmetic shift, saturate to 16 bits
	function automatic logic signed [OUT_W-1:0] round_sat(
		input logic signed [PROD_W-1:0] v,
		input int sh
	);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] t;
		bias = '0;
		bias[sh-1] = 1'b1;
		t = (v + bias) >>> sh;
		if (t > OUT_MAX_P)
			t = OUT_MAX_P;
		else if (t < OUT_MIN_P)
			t = OUT_MIN_P;
		return t[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cmvg_div.sv =====
// Pipelined restoring divider: angle and ring quotients, four bits per stage
`default_nettype none

module cmvg_div
	import cmvg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [REM_W-1:0]     in_rem [DIV_LANES],
	input  logic                 in_full,
	input  logic [REM_W-1:0]     divisor [DIV_LANES],
	output logic                 out_valid,
	output logic [DIV_STEPS-1:0] out_quot [DIV_LANES],
	output logic                 out_full
);

	logic                 valid_s [DIV_STAGES];
	logic                 full_s  [DIV_STAGES];
	logic [REM_W-1:0]     rem_s   [DIV_STAGES][DIV_LANES];
	logic [DIV_STEPS-1:0] quot_s  [DIV_STAGES][DIV_LANES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic                 v_in;
		logic                 f_in;
		logic [REM_W-1:0]     rem_in  [DIV_LANES];
		logic [DIV_STEPS-1:0] quot_in [DIV_LANES];
		logic [REM_W-1:0]     rem_nx  [DIV_LANES];
		logic [DIV_STEPS-1:0] quot_nx [DIV_LANES];

		if (j == 0) begin : g_head
			assign v_in    = in_valid;
			assign f_in    = in_full;
			assign rem_in  = in_rem;
			assign quot_in = '{default: '0};
		end else begin : g_body
			assign v_in    = valid_s[j-1];
			assign f_in    = full_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quot_in = quot_s[j-1];
		end

		always_comb begin
			logic [REM_W-1:0]     r;
			logic [REM_W-1:0]     sh;
			logic [DIV_STEPS-1:0] q;
			for (int l = 0; l < DIV_LANES; l++) begin
				r = rem_in[l];
				q = quot_in[l];
				for (int t = 0; t < DIV_PER_STAGE; t++) begin
					sh = {r[REM_W-2:0], 1'b0};
					if (sh >= divisor[l]) begin
						r = sh - divisor[l];
						q = {q[DIV_STEPS-2:0], 1'b1};
					end else begin
						r = sh;
						q = {q[DIV_STEPS-2:0], 1'b0};
					end
				end
				rem_nx[l]  = r;
				quot_nx[l] = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[j] <= 1'b0;
			else
				valid_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			full_s[j] <= f_in;
			rem_s[j]  <= rem_nx;
			quot_s[j] <= quot_nx;
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_full  = full_s[DIV_STAGES-1];
	assign out_quot  = quot_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/cmvg_cordic.sv =====
// Pipelined CORDIC rotator for both wedge angles, three iterations per stage
`default_nettype none

module cmvg_cordic
	import cmvg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [DIV_STEPS-1:0] in_phase [TRIG_LANES],
	input  ring_t                in_ring,
	output logic                 out_valid,
	output cordic_t              out_trig [TRIG_LANES],
	output ring_t                out_ring
);

	logic                 valid_s [CORDIC_STAGES];
	ring_t                ring_s  [CORDIC_STAGES];
	logic [1:0]           quad_s  [CORDIC_STAGES][TRIG_LANES];
	logic signed [CW-1:0] x_s     [CORDIC_STAGES][TRIG_LANES];
	logic signed [CW-1:0] y_s     [CORDIC_STAGES][TRIG_LANES];
	logic signed [ZW-1:0] z_s     [CORDIC_STAGES][TRIG_LANES];

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
		logic                 v_in;
		ring_t                ring_in;
		logic [1:0]           quad_in [TRIG_LANES];
		logic signed [CW-1:0] x_in    [TRIG_LANES];
		logic signed [CW-1:0] y_in    [TRIG_LANES];
		logic signed [ZW-1:0] z_in    [TRIG_LANES];
		logic signed [CW-1:0] x_nx    [TRIG_LANES];
		logic signed [CW-1:0] y_nx    [TRIG_LANES];
		logic signed [ZW-1:0] z_nx    [TRIG_LANES];

		if (j == 0) begin : g_head
			assign v_in    = in_valid;
			assign ring_in = in_ring;
			for (genvar l = 0; l < TRIG_LANES; l++) begin : g_lane
				assign quad_in[l] = in_phase[l][DIV_STEPS-1:DIV_STEPS-2];
				assign x_in[l]    = CORDIC_GAIN;
				assign y_in[l]    = '0;
				assign z_in[l]    = $signed({3'b000, in_phase[l][DIV_STEPS-3:0]});
			end
		end else begin : g_body
			assign v_in    = valid_s[j-1];
			assign ring_in = ring_s[j-1];
			assign quad_in = quad_s[j-1];
			assign x_in    = x_s[j-1];
			assign y_in    = y_s[j-1];
			assign z_in    = z_s[j-1];
		end

		always_comb begin
			logic signed [CW-1:0] x;
			logic signed [CW-1:0] y;
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			logic signed [ZW-1:0] z;
			logic signed [ZW-1:0] at;
			int k;
			for (int l = 0; l < TRIG_LANES; l++) begin
				x = x_in[l];
				y = y_in[l];
				z = z_in[l];
				for (int t = 0; t < CORDIC_PER_STAGE; t++) begin
					k  = j * CORDIC_PER_STAGE + t;
					dx = y >>> k;
					dy = x >>> k;
					at = $signed({1'b0, ATAN_TURN[k]});
					if (!z[ZW-1]) begin
						x = x - dx;
						y = y + dy;
						z = z - at;
					end else begin
						x = x + dx;
						y = y - dy;
						z = z + at;
					end
				end
				x_nx[l] = x;
				y_nx[l] = y;
				z_nx[l] = z;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[j] <= 1'b0;
			else
				valid_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			ring_s[j] <= ring_in;
			quad_s[j] <= quad_in;
			x_s[j]    <= x_nx;
			y_s[j]    <= y_nx;
			z_s[j]    <= z_nx;
		end
	end

	assign out_valid = valid_s[CORDIC_STAGES-1];
	assign out_ring  = ring_s[CORDIC_STAGES-1];
	for (genvar l = 0; l < TRIG_LANES; l++) begin : g_out
		assign out_trig[l] = '{
			quad: quad_s[CORDIC_STAGES-1][l],
			x:    x_s[CORDIC_STAGES-1][l],
			y:    y_s[CORDIC_STAGES-1][l]
		};
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cmvg_emit.sv =====
// Vertex sequencer: twelve vertices per item through select, multiply and round stages
`default_nettype none
`include "cone_mesh_vertex_generator_macros.svh"

module cmvg_emit
	import cmvg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  cordic_t                 in_trig [TRIG_LANES],
	input  ring_t                   in_ring,
	output logic                    vertex_valid,
	output logic signed [OUT_W-1:0] pos_x,
	output logic signed [OUT_W-1:0] pos_y,
	output logic signed [OUT_W-1:0] pos_z,
	output logic signed [OUT_W-1:0] norm_x,
	output logic signed [OUT_W-1:0] norm_y,
	output logic signed [OUT_W-1:0] norm_z,
	output logic                    last_vertex
);

	logic signed [CW-1:0] c_ld [TRIG_LANES];
	logic signed [CW-1:0] s_ld [TRIG_LANES];

	always_comb begin
		for (int l = 0; l < TRIG_LANES; l++) begin
			case (in_trig[l].quad)
				2'd0: begin
					c_ld[l] = in_trig[l].x;
					s_ld[l] = in_trig[l].y;
				end
				2'd1: begin
					c_ld[l] = -in_trig[l].y;
					s_ld[l] = in_trig[l].x;
				end
				2'd2: begin
					c_ld[l] = -in_trig[l].x;
					s_ld[l] = -in_trig[l].y;
				end
				default: begin
					c_ld[l] = in_trig[l].y;
					s_ld[l] = -in_trig[l].x;
				end
			endcase
		end
	end

	// per-item hold
	logic                 active_q;
	logic [VTX_W-1:0]     vtx_q;
	logic signed [CW-1:0] ca_q, sa_q, cb_q, sb_q;
	logic signed [CW:0]   csum_q, ssum_q;
	ring_t                ring_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			vtx_q    <= '0;
		end else if (in_valid) begin
			active_q <= 1'b1;
			vtx_q    <= '0;
		end else if (active_q) begin
			if (vtx_q == VTX_LAST)
				active_q <= 1'b0;
			else
				vtx_q <= vtx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			ca_q   <= c_ld[LANE_A];
			sa_q   <= s_ld[LANE_A];
			cb_q   <= c_ld[LANE_B];
			sb_q   <= s_ld[LANE_B];
			csum_q <= (CW+1)'(c_ld[LANE_A]) + (CW+1)'(c_ld[LANE_B]);
			ssum_q <= (CW+1)'(s_ld[LANE_A]) + (CW+1)'(s_ld[LANE_B]);
			ring_q <= in_ring;
		end
	end

	// select
	vsel_t                 sel;
	logic signed [CW-1:0]  cc, ss;
	logic [RAD_W-1:0]      rad;
	logic                  tip_nrm;

	always_comb begin
		sel     = vtx_sel(vtx_q);
		cc      = sel.use_b ? cb_q : ca_q;
		ss      = sel.use_b ? sb_q : sa_q;
		if (sel.base)
			rad = sel.top ? ring_q.r1 : ring_q.r2;
		else
			rad = sel.top ? ring_q.sr2 : ring_q.sr1;
		tip_nrm = !sel.base && sel.top && ring_q.tip;
	end

	logic                    valid_s1, last_s1, base_s1;
	logic signed [RAD_W:0]   rad_s1;
	logic signed [CW-1:0]    c_s1, s_s1;
	logic signed [CW:0]      cn_s1, sn_s1;
	logic signed [YW-1:0]    y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= active_q;
	end

	always_ff @(posedge clk) begin
		last_s1 <= (vtx_q == VTX_LAST);
		base_s1 <= sel.base;
		rad_s1  <= $signed({1'b0, rad});
		c_s1    <= cc;
		s_s1    <= ss;
		cn_s1   <= tip_nrm ? csum_q : $signed({cc, 1'b0});
		sn_s1   <= tip_nrm ? ssum_q : $signed({ss, 1'b0});
		y_s1    <= sel.top ? ring_q.y2 : ring_q.y1;
	end

	// multiply
	logic                     valid_s2, last_s2, base_s2;
	logic signed [PROD_W-1:0] px_s2, pz_s2, nx_s2, nz_s2;
	logic signed [YW-1:0]     y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		base_s2 <= base_s1;
		px_s2   <= PROD_W'(rad_s1) * PROD_W'(c_s1);
		pz_s2   <= PROD_W'(rad_s1) * PROD_W'(s_s1);
		nx_s2   <= PROD_W'(cn_s1) * PROD_W'(NRM_K);
		nz_s2   <= PROD_W'(sn_s1) * PROD_W'(NRM_K);
		y_s2    <= y_s1;
	end

	// round and saturate
	logic                    valid_s3, last_s3;
	logic signed [OUT_W-1:0] px_s3, py_s3, pz_s3, nx_s3, ny_s3, nz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		last_s3 <= last_s2;
		px_s3   <= round_sat(px_s2, PP);
		pz_s3   <= round_sat(pz_s2, PP);
		if (base_s2) begin
			py_s3 <= POS_Y_BASE;
			nx_s3 <= '0;
			ny_s3 <= NORM_Y_BASE;
			nz_s3 <= '0;
		end else begin
			py_s3 <= round_sat(PROD_W'(y_s2), PS);
			nx_s3 <= round_sat(nx_s2, PP + 1);
			ny_s3 <= NORM_Y_SIDE;
			nz_s3 <= round_sat(nz_s2, PP + 1);
		end
	end

	assign vertex_valid = valid_s3;
	assign last_vertex  = valid_s3 && last_s3;
	assign pos_x        = px_s3;
	assign pos_y        = py_s3;
	assign pos_z        = pz_s3;
	assign norm_x       = nx_s3;
	assign norm_y       = ny_s3;
	assign norm_z       = nz_s3;

	`CMVG_ASSERT_IMPL(a_load_when_free, in_valid, !active_q || vtx_q == VTX_LAST, "item overran sequencer")
	`CMVG_ASSERT_IMPL(a_last_after_run, vertex_valid && last_vertex, $past(vertex_valid, 11), "short vertex run")

endmodule

`default_nettype wire

// ===== hw/rtl/cone_mesh_vertex_generator.sv =====
// Top level of the cone mesh vertex generator: register port, input stage, pipeline
`default_nettype none
`include "cone_mesh_vertex_generator_macros.svh"

// Cone tessellator. Registers on the APB port: ring_count at 0x0, segment_count
// at 0x4; write them only while the block is idle.
// A transaction is taken at a clock edge with start high and busy low; it names
// one wedge (segment_index) and one ring (ring_index), out-of-range values clamp.
// It yields twelve vertices on the result ports, one per cycle, each marked by
// vertex_valid for one cycle; last_vertex flags the twelfth.
// Path after the input register: 8-stage divider, 10-stage CORDIC, sequencer
// load, 3-stage vertex select, multiply and round.
// Transactions overlap in the divider and CORDIC; the one-vertex-per-cycle
// result port sets the pace: busy rises after each accept and stays high
// until the sequencer can take the next transaction.
// The receiver cannot stall; results are always taken.
// Reset clears the registers to 1 ring and 3 segments and empties the pipeline.

module cone_mesh_vertex_generator
	import cmvg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic [SIDX_W-1:0]       segment_index,
	input  logic [RIDX_W-1:0]       ring_index,
	output logic                    vertex_valid,
	output logic signed [OUT_W-1:0] pos_x,
	output logic signed [OUT_W-1:0] pos_y,
	output logic signed [OUT_W-1:0] pos_z,
	output logic signed [OUT_W-1:0] norm_x,
	output logic signed [OUT_W-1:0] norm_y,
	output logic signed [OUT_W-1:0] norm_z,
	output logic                    last_vertex
);

	// register port
	logic [RC_W-1:0] ring_count_q;
	logic [SC_W-1:0] segment_count_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= RC_W'(1);
			segment_count_q <= SC_W'(MIN_SEGMENTS);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RING_COUNT:    ring_count_q    <= pwdata[RC_W-1:0];
				REG_SEGMENT_COUNT: segment_count_q <= pwdata[SC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RING_COUNT:    prdata = PDATA_W'(ring_count_q);
			REG_SEGMENT_COUNT: prdata = PDATA_W'(segment_count_q);
			default:           prdata = '0;
		endcase
	end

	// accept gap
	logic [VTX_W-1:0] gap_q;
	logic             accept;

	assign busy   = (gap_q != '0);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_q <= '0;
		else if (accept)
			gap_q <= VTX_LAST;
		else if (busy)
			gap_q <= gap_q - 1'b1;
	end

	// clamping and divider seeds
	logic [RC_W-1:0]   r_eff;
	logic [SC_W-1:0]   s_eff;
	logic [SC_W-1:0]   seg_c;
	logic [RC_W-1:0]   ring_c;
	logic [SC_W-1:0]   seg_p1;
	logic [RC_W-1:0]   ring_p1;
	logic [REM_W-1:0]  divisor [DIV_LANES];

	always_comb begin
		if (ring_count_q == '0)
			r_eff = RC_W'(1);
		else if (ring_count_q > RC_W'(MAX_RINGS))
			r_eff = RC_W'(MAX_RINGS);
		else
			r_eff = ring_count_q;
		if (segment_count_q < SC_W'(MIN_SEGMENTS))
			s_eff = SC_W'(MIN_SEGMENTS);
		else if (segment_count_q > SC_W'(MAX_SEGMENTS))
			s_eff = SC_W'(MAX_SEGMENTS);
		else
			s_eff = segment_count_q;
		seg_c   = (SC_W'(segment_index) > s_eff - 1'b1) ? s_eff - 1'b1 : SC_W'(segment_index);
		ring_c  = (RC_W'(ring_index) > r_eff - 1'b1) ? r_eff - 1'b1 : RC_W'(ring_index);
		seg_p1  = seg_c + 1'b1;
		ring_p1 = ring_c + 1'b1;
	end

	assign divisor[LANE_A]  = REM_W'(s_eff);
	assign divisor[LANE_B]  = REM_W'(s_eff);
	assign divisor[LANE_R1] = REM_W'(r_eff);
	assign divisor[LANE_R2] = REM_W'(r_eff);

	logic             valid_s1;
	logic             full_s1;
	logic [REM_W-1:0] rem_s1 [DIV_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	// the wedge that closes the turn wraps to angle zero
	always_ff @(posedge clk) begin
		rem_s1[LANE_A]  <= REM_W'(seg_c);
		rem_s1[LANE_B]  <= (seg_p1 == s_eff) ? '0 : REM_W'(seg_p1);
		rem_s1[LANE_R1] <= REM_W'(ring_c);
		rem_s1[LANE_R2] <= (ring_p1 == r_eff) ? '0 : REM_W'(ring_p1);
		full_s1         <= (ring_p1 == r_eff);
	end

	logic                 div_valid;
	logic [DIV_STEPS-1:0] div_quot [DIV_LANES];
	logic                 div_full;

	cmvg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_rem    (rem_s1),
		.in_full   (full_s1),
		.divisor   (divisor),
		.out_valid (div_valid),
		.out_quot  (div_quot),
		.out_full  (div_full)
	);

	// ring radii (unsigned Q0.30) and heights (signed, 30 fraction bits)
	ring_t                ring_geo;
	logic [DIV_STEPS-1:0] phase [TRIG_LANES];
	logic [RAD_W-1:0]     r1, r2;
	logic signed [YW-1:0] y1, y2;

	always_comb begin
		r1 = RAD_W'(div_quot[LANE_R1] >> 3);
		y1 = $signed({1'b0, div_quot[LANE_R1][DIV_STEPS-1:2]}) - HALF_Y;
		if (div_full) begin
			r2 = HALF_RAD;
			y2 = HALF_Y;
		end else begin
			r2 = RAD_W'(div_quot[LANE_R2] >> 3);
			y2 = $signed({1'b0, div_quot[LANE_R2][DIV_STEPS-1:2]}) - HALF_Y;
		end
		ring_geo = '{
			r1:  r1,
			r2:  r2,
			sr1: HALF_RAD - r1,
			sr2: HALF_RAD - r2,
			y1:  y1,
			y2:  y2,
			tip: div_full
		};
	end

	assign phase[LANE_A] = div_quot[LANE_A];
	assign phase[LANE_B] = div_quot[LANE_B];

	logic    cor_valid;
	cordic_t cor_trig [TRIG_LANES];
	ring_t   cor_ring;

	cmvg_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_phase  (phase),
		.in_ring   (ring_geo),
		.out_valid (cor_valid),
		.out_trig  (cor_trig),
		.out_ring  (cor_ring)
	);

	cmvg_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cor_valid),
		.in_trig      (cor_trig),
		.in_ring      (cor_ring),
		.vertex_valid (vertex_valid),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.last_vertex  (last_vertex)
	);

	`CMVG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	`CMVG_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start), "busy rose without a transaction")

endmodule

`default_nettype wire
